>>> hdl/des_pkg.sv
`timescale 1ns / 1ps
// DES tables, types and permutation functions shared by the cipher pipeline
package des_pkg;

    localparam int ROUNDS = 16;

    typedef logic [47:0] t_subkey;
    typedef t_subkey     t_subkey_arr [0:ROUNDS-1];
    typedef logic [31:0] t_half;

    localparam logic [6:0] T_IP [0:63] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

    localparam logic [6:0] T_FP [0:63] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

    localparam logic [5:0] T_E [0:47] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

    localparam logic [5:0] T_P [0:31] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

    localparam logic [6:0] T_PC1 [0:55] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
        7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
        7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
        7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

    localparam logic [5:0] T_PC2 [0:47] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
        6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
        6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
        6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
        6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

    // cumulative left rotation of C and D after each round
    localparam logic [4:0] T_ROT_SUM [0:ROUNDS-1] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28};

    localparam logic [3:0] T_SBOX [0:7][0:3][0:15] = '{
        '{'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
            4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
          '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
            4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
          '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
            4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
          '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
            4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13}},
        '{'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
            4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
          '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
            4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
          '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
            4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
          '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
            4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9}},
        '{'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
            4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
          '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
            4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
          '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
            4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
          '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
            4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12}},
        '{'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
            4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
          '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
            4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
          '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
            4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
          '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
            4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14}},
        '{'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
            4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
          '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
            4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
          '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
            4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
          '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
            4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3}},
        '{'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
            4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
          '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
            4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
          '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
            4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
          '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
            4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13}},
        '{'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
            4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
          '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
            4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
          '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
            4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
          '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
            4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12}},
        '{'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
            4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
          '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
            4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
          '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
            4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
          '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
            4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}}};

    function automatic logic [63:0] perm_ip(input logic [63:0] src);
        logic [63:0] res;
        res = '0;
        for (int i = 0; i < 64; i++) res[63-i] = src[64 - int'(T_IP[i])];
        return res;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] src);
        logic [63:0] res;
        res = '0;
        for (int i = 0; i < 64; i++) res[63-i] = src[64 - int'(T_FP[i])];
        return res;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] src);
        logic [55:0] res;
        res = '0;
        for (int i = 0; i < 56; i++) res[55-i] = src[64 - int'(T_PC1[i])];
        return res;
    endfunction

    function automatic t_subkey perm_pc2(input logic [55:0] src);
        t_subkey res;
        res = '0;
        for (int i = 0; i < 48; i++) res[47-i] = src[56 - int'(T_PC2[i])];
        return res;
    endfunction

    function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [4:0] s);
        logic [55:0] dbl;
        dbl = {v, v} << s;
        return dbl[55:28];
    endfunction

    function automatic t_half feistel(input t_half half, input t_subkey key);
        t_subkey     mix;
        t_half       sout;
        t_half       res;
        logic [5:0]  six;
        mix  = '0;
        sout = '0;
        res  = '0;
        for (int i = 0; i < 48; i++) mix[47-i] = half[32 - int'(T_E[i])];
        mix = mix ^ key;
        for (int b = 0; b < 8; b++) begin
            six = mix[42 - 6*b +: 6];
            sout[28 - 4*b +: 4] = T_SBOX[b][{six[5], six[0]}][six[4:1]];
        end
        for (int i = 0; i < 32; i++) res[31-i] = sout[32 - int'(T_P[i])];
        return res;
    endfunction

endpackage

>>> hdl/des_key_sched.sv
`timescale 1ns / 1ps
// DES key schedule: registered round keys in application order
module des_key_sched
    import des_pkg::*;
(
    input  logic        i_clk,
    input  logic [63:0] i_cipher_key,
    input  logic        i_encrypt_mode,
    output t_subkey_arr o_subkeys
);

    t_subkey_arr r_subkeys;
    t_subkey_arr n_subkeys;
    t_subkey_arr w_sched;
    logic [55:0] w_k56;

    always_comb begin
        w_k56 = perm_pc1(i_cipher_key);
        for (int r = 0; r < ROUNDS; r++) begin
            w_sched[r] = perm_pc2({rotl28(w_k56[55:28], T_ROT_SUM[r]),
                                   rotl28(w_k56[27:0],  T_ROT_SUM[r])});
        end
        for (int r = 0; r < ROUNDS; r++) begin
            n_subkeys[r] = i_encrypt_mode ? w_sched[r] : w_sched[ROUNDS-1-r];
        end
    end

    always_ff @(posedge i_clk) begin
        r_subkeys <= n_subkeys;
    end

    assign o_subkeys = r_subkeys;

endmodule

>>> hdl/des_round.sv
`timescale 1ns / 1ps
// One registered DES Feistel round stage
module des_round
    import des_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_half   i_left,
    input  t_half   i_right,
    input  t_subkey i_subkey,
    output logic    o_valid,
    output t_half   o_left,
    output t_half   o_right
);

    logic  r_valid;
    t_half r_left;
    t_half r_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= i_right;
        r_right <= i_left ^ feistel(i_right, i_subkey);
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

>>> hdl/des_block_cipher.sv
`timescale 1ns / 1ps
// DES block cipher top level: register port, IP stage, sixteen round stages, FP stage
//
// A request is taken on every cycle in which start is high; busy never rises, and one
// block enters per clock. The result appears on o_result_block with o_result_valid high
// for one cycle, having passed one register after IP, one per Feistel round and one after
// FP. Results leave in request order and the receiver cannot stall.
// Key and mode sit at byte addresses 0x0 and 0x8; round keys are registered from them,
// so a request may follow a register write on the next cycle.
module des_block_cipher
    import des_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_data_block,
    output logic        o_result_valid,
    output logic [63:0] o_result_block
);

    localparam logic REG_KEY  = 1'b0;
    localparam logic REG_MODE = 1'b1;

    logic [63:0] r_cipher_key;
    logic        r_encrypt_mode;
    logic        w_wr;

    logic        r_ip_valid;
    logic [63:0] r_ip_block;
    logic [63:0] w_ip_block;

    logic        w_valid [0:ROUNDS];
    t_half       w_left  [0:ROUNDS];
    t_half       w_right [0:ROUNDS];
    t_subkey_arr w_subkeys;

    logic        r_out_valid;
    logic [63:0] r_out_block;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key   <= '0;
            r_encrypt_mode <= 1'b1;
        end else if (w_wr) begin
            case (paddr[3])
                REG_KEY:  r_cipher_key   <= pwdata;
                REG_MODE: r_encrypt_mode <= pwdata[0];
                default:  r_cipher_key   <= r_cipher_key;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_KEY:  prdata = r_cipher_key;
            REG_MODE: prdata = {63'd0, r_encrypt_mode};
            default:  prdata = '0;
        endcase
    end

    des_key_sched u_key_sched (
        .i_clk          (i_clk),
        .i_cipher_key   (r_cipher_key),
        .i_encrypt_mode (r_encrypt_mode),
        .o_subkeys      (w_subkeys)
    );

    assign w_ip_block = perm_ip(i_data_block);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_valid <= 1'b0;
        end else begin
            r_ip_valid <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ip_block <= w_ip_block;
    end

    assign w_valid[0] = r_ip_valid;
    assign w_left[0]  = r_ip_block[63:32];
    assign w_right[0] = r_ip_block[31:0];

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        des_round u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_valid[g]),
            .i_left   (w_left[g]),
            .i_right  (w_right[g]),
            .i_subkey (w_subkeys[g]),
            .o_valid  (w_valid[g+1]),
            .o_left   (w_left[g+1]),
            .o_right  (w_right[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_valid[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_block <= perm_fp({w_right[ROUNDS], w_left[ROUNDS]});
    end

    assign o_result_valid = r_out_valid;
    assign o_result_block = r_out_block;

endmodule
